### design/thermistor_code_to_temperature_top_macros.svh
// assertion macros of the thermistor converter checker
`ifndef THERMISTOR_CODE_TO_TEMPERATURE_TOP_MACROS_SVH
`define THERMISTOR_CODE_TO_TEMPERATURE_TOP_MACROS_SVH

// implication checked in the same cycle, off while reset is high
`define TCT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tct assertion failed");

// implication checked in the next cycle, active during reset too
`define TCT_ASSERT_NXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("tct assertion failed");

`endif

### design/tct_pkg.sv
// types, widths and constants of the thermistor code to temperature converter
package tct_pkg;

   localparam int COEFF_FRAC_BITS = 48;

   localparam int COEFF_W    = 48;
   localparam int SUPPLY_W   = 15;
   localparam int OHMS_W     = 20;
   localparam int CODE_W     = 16;
   localparam int TEMP_W     = 16;
   localparam int STATUS_W   = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 48;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_COEFF_A        = 3'd0,
      REG_COEFF_B        = 3'd1,
      REG_COEFF_C        = 3'd2,
      REG_COEFF_D        = 3'd3,
      REG_SUPPLY_CODE    = 3'd4,
      REG_SERIES_OHMS    = 3'd5,
      REG_REFERENCE_OHMS = 3'd6
   } csr_index_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_SAT   = 2'd2
   } status_type;

   localparam logic signed [COEFF_W-1:0] RST_COEFF_A = 48'sd281474976711;
   localparam logic signed [COEFF_W-1:0] RST_COEFF_B = 48'sd56294995342;
   localparam logic signed [COEFF_W-1:0] RST_COEFF_C = 48'sd0;
   localparam logic signed [COEFF_W-1:0] RST_COEFF_D = 48'sd28147498;
   localparam logic [SUPPLY_W-1:0]       RST_SUPPLY  = 15'd14400;
   localparam logic [OHMS_W-1:0]         RST_SERIES  = 20'd10000;
   localparam logic [OHMS_W-1:0]         RST_REF     = 20'd10000;

   // log2 datapath
   localparam int XFRAC  = 30;
   localparam int M_W    = XFRAC + 1;
   localparam int PROD_W = OHMS_W + SUPPLY_W;
   localparam int P_W    = $clog2(PROD_W);
   localparam int LOG_W  = P_W + XFRAC;
   localparam int LO_W   = LOG_W / 2;
   localparam int HI_W   = LOG_W - LO_W;
   localparam int LN2_W  = 28;
   localparam logic [LN2_W-1:0] LN2_Q28 = 28'd186065279;

   // polynomial datapath
   localparam int X_W  = LOG_W;
   localparam int T_W  = 64;
   localparam int TM_W = T_W - 1;
   localparam int TL_W = 32;
   localparam int TH_W = TM_W - TL_W;
   localparam int PR_W = X_W + TM_W + 1;
   localparam logic [T_W-1:0] LIMIT = T_W'(1) << (T_W - 2);
   localparam int HORNER_STEPS = 3;

   // reciprocal datapath
   localparam int QUO_BITS = 16;
   localparam int N_W   = (COEFF_FRAC_BITS + 8 > TM_W) ? COEFF_FRAC_BITS + 8 : TM_W;
   localparam int DIV_W = TM_W + QUO_BITS + 1;
   localparam logic [N_W-1:0] K_NUM = N_W'(100) << COEFF_FRAC_BITS;
   localparam int KELVIN_OFFSET = 27315;

   localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sd32767;
   localparam logic signed [TEMP_W-1:0] TEMP_MIN = -16'sd32768;

   localparam int LATENCY = 4 + XFRAC + 3 + 4 * HORNER_STEPS + 1 + QUO_BITS + 1;

endpackage

### design/thermistor_code_to_temperature_top.sv
// thermistor code to temperature converter, fully pipelined steinhart-hart datapath
//
// One adc beat enters per clock (start high while busy is low; busy is high only
// during reset) and its temperature beat leaves on rsp_valid, for one cycle, with
// no way to hold it off. The pipeline is a chain of stages: resistor products,
// normalization, 30 squaring stages per log2, ln scaling, three multiply-add
// steps of four stages each and a 16-bit restoring reciprocal, one quotient bit
// per stage. Configuration registers are written through csr_we/csr_addr/csr_wdata
// and must be left alone while beats are in flight.
module thermistor_code_to_temperature_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [tct_pkg::CODE_W-1:0]     req_adc_code,
   input  logic                                  csr_we,
   input  logic [tct_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [tct_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output logic                                  rsp_valid,
   output logic signed [tct_pkg::TEMP_W-1:0]     rsp_temp_centi_c,
   output logic [tct_pkg::STATUS_W-1:0]          rsp_status
);
   import tct_pkg::*;

   localparam int TK_W = QUO_BITS + 3;
   localparam logic signed [TK_W-1:0] TK_MAX = TK_W'(TEMP_MAX);
   localparam logic signed [TK_W-1:0] TK_MIN = TK_W'(TEMP_MIN);
   localparam logic signed [TK_W-1:0] TK_OFF = TK_W'(KELVIN_OFFSET);
   localparam logic signed [T_W-1:0]  LIM_P  = LIMIT;
   localparam logic signed [T_W-1:0]  LIM_N  = -LIMIT;

   // configuration registers
   logic signed [COEFF_W-1:0] coeff_a_ff, coeff_b_ff, coeff_c_ff, coeff_d_ff;
   logic [SUPPLY_W-1:0]       supply_code_ff;
   logic [OHMS_W-1:0]         series_ohms_ff, reference_ohms_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_a_ff        <= RST_COEFF_A;
         coeff_b_ff        <= RST_COEFF_B;
         coeff_c_ff        <= RST_COEFF_C;
         coeff_d_ff        <= RST_COEFF_D;
         supply_code_ff    <= RST_SUPPLY;
         series_ohms_ff    <= RST_SERIES;
         reference_ohms_ff <= RST_REF;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            REG_COEFF_A:        coeff_a_ff <= csr_wdata[COEFF_W-1:0];
            REG_COEFF_B:        coeff_b_ff <= csr_wdata[COEFF_W-1:0];
            REG_COEFF_C:        coeff_c_ff <= csr_wdata[COEFF_W-1:0];
            REG_COEFF_D:        coeff_d_ff <= csr_wdata[COEFF_W-1:0];
            REG_SUPPLY_CODE:    supply_code_ff <= csr_wdata[SUPPLY_W-1:0];
            REG_SERIES_OHMS:    series_ohms_ff <= csr_wdata[OHMS_W-1:0];
            REG_REFERENCE_OHMS: reference_ohms_ff <= csr_wdata[OHMS_W-1:0];
            default: ;
         endcase
      end
   end

   function automatic logic [P_W-1:0] top_bit(input logic [PROD_W-1:0] n);
      logic [P_W-1:0] p;
      p = '0;
      for (int i = 0; i < PROD_W; i++) begin
         if (n[i]) p = P_W'(i);
      end
      return p;
   endfunction

   // one squaring round: msb is the fraction bit, rest the new mantissa
   function automatic logic [M_W:0] sq_step(input logic [M_W-1:0] m);
      logic [2*M_W-1:0] sq;
      logic [M_W:0]     r;
      sq = (2*M_W)'(m) * (2*M_W)'(m);
      r  = sq[XFRAC +: M_W+1];
      if (r[M_W]) return {1'b1, r[M_W:1]};
      else return {1'b0, r[M_W-1:0]};
   endfunction

   // valid and out-of-range flags travel with the beat
   logic               accept;
   logic               bad_in;
   logic [LATENCY-1:0] vld_ff;
   logic [LATENCY-1:0] bad_ff;

   assign busy   = reset;
   assign accept = start && !busy;
   assign bad_in = req_adc_code[CODE_W-1] || (req_adc_code == '0) ||
                   (req_adc_code[SUPPLY_W-1:0] >= supply_code_ff) ||
                   (series_ohms_ff == '0) || (reference_ohms_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[LATENCY-2:0], accept};
      bad_ff <= {bad_ff[LATENCY-2:0], bad_in};
   end

   // stages 1 to 4: code, resistor products, top bit, mantissa
   logic [SUPPLY_W-1:0] s1_code_ff;
   logic [PROD_W-1:0]   s2_num_ff, s2_den_ff, s3_num_ff, s3_den_ff;
   logic [P_W-1:0]      s3_pn_ff, s3_pd_ff;
   logic [SUPPLY_W-1:0] diff;

   assign diff = supply_code_ff - s1_code_ff;

   logic [M_W-1:0]   lg_mn_ff [0:XFRAC];
   logic [M_W-1:0]   lg_md_ff [0:XFRAC];
   logic [P_W-1:0]   lg_pn_ff [0:XFRAC];
   logic [P_W-1:0]   lg_pd_ff [0:XFRAC];
   logic [XFRAC-1:0] lg_fn_ff [0:XFRAC];
   logic [XFRAC-1:0] lg_fd_ff [0:XFRAC];

   always_ff @(posedge clock) begin
      s1_code_ff  <= req_adc_code[SUPPLY_W-1:0];
      s2_num_ff   <= PROD_W'(series_ohms_ff) * PROD_W'(s1_code_ff);
      s2_den_ff   <= PROD_W'(diff) * PROD_W'(reference_ohms_ff);
      s3_num_ff   <= s2_num_ff;
      s3_den_ff   <= s2_den_ff;
      s3_pn_ff    <= top_bit(s2_num_ff);
      s3_pd_ff    <= top_bit(s2_den_ff);
      // n * 2^(30-p), truncated when p is above 30
      lg_mn_ff[0] <= M_W'({s3_num_ff, {XFRAC{1'b0}}} >> s3_pn_ff);
      lg_md_ff[0] <= M_W'({s3_den_ff, {XFRAC{1'b0}}} >> s3_pd_ff);
      lg_pn_ff[0] <= s3_pn_ff;
      lg_pd_ff[0] <= s3_pd_ff;
      lg_fn_ff[0] <= '0;
      lg_fd_ff[0] <= '0;
   end

   // stages 5 to 34: one fraction bit of each log2 per stage
   for (genvar i = 0; i < XFRAC; i++) begin : g_log
      logic [M_W:0]     rn, rd;
      logic [XFRAC-1:0] fn_in, fd_in;
      always_comb begin
         rn    = sq_step(lg_mn_ff[i]);
         rd    = sq_step(lg_md_ff[i]);
         fn_in = lg_fn_ff[i];
         fd_in = lg_fd_ff[i];
         fn_in[XFRAC-1-i] = rn[M_W];
         fd_in[XFRAC-1-i] = rd[M_W];
      end
      always_ff @(posedge clock) begin
         lg_mn_ff[i+1] <= rn[M_W-1:0];
         lg_md_ff[i+1] <= rd[M_W-1:0];
         lg_pn_ff[i+1] <= lg_pn_ff[i];
         lg_pd_ff[i+1] <= lg_pd_ff[i];
         lg_fn_ff[i+1] <= fn_in;
         lg_fd_ff[i+1] <= fd_in;
      end
   end

   // stages 35 to 37: log ratio, times ln 2 in two partial products
   logic signed [LOG_W:0]    d_in;
   logic [LOG_W-1:0]         s35_ud_ff;
   logic                     s35_neg_ff, s36_neg_ff;
   logic [LO_W+LN2_W-1:0]    s36_pl_ff;
   logic [HI_W+LN2_W-1:0]    s36_ph_ff;
   logic [LOG_W+LN2_W:0]     ux_sum;
   logic signed [T_W-1:0]    cd_ext;

   assign d_in   = $signed({1'b0, lg_pn_ff[XFRAC], lg_fn_ff[XFRAC]}) -
                   $signed({1'b0, lg_pd_ff[XFRAC], lg_fd_ff[XFRAC]});
   assign ux_sum = {1'b0, s36_ph_ff, {LO_W{1'b0}}} + (LOG_W+LN2_W+1)'(s36_pl_ff);
   assign cd_ext = {{(T_W-COEFF_W){coeff_d_ff[COEFF_W-1]}}, coeff_d_ff};

   // step boundaries of the polynomial: index 0 holds x and coeff_d
   logic [TM_W-1:0] hb_tm_ff [0:HORNER_STEPS];
   logic            hb_tn_ff [0:HORNER_STEPS];
   logic [X_W-1:0]  hb_x_ff  [0:HORNER_STEPS];
   logic            hb_xn_ff [0:HORNER_STEPS];

   always_ff @(posedge clock) begin
      s35_neg_ff  <= d_in[LOG_W];
      s35_ud_ff   <= d_in[LOG_W] ? LOG_W'(-d_in) : LOG_W'(d_in);
      s36_neg_ff  <= s35_neg_ff;
      s36_pl_ff   <= (LO_W+LN2_W)'(s35_ud_ff[LO_W-1:0]) * (LO_W+LN2_W)'(LN2_Q28);
      s36_ph_ff   <= (HI_W+LN2_W)'(s35_ud_ff[LOG_W-1:LO_W]) * (HI_W+LN2_W)'(LN2_Q28);
      hb_x_ff[0]  <= ux_sum[LN2_W +: X_W];
      hb_xn_ff[0] <= s36_neg_ff;
      hb_tn_ff[0] <= cd_ext[T_W-1];
      hb_tm_ff[0] <= cd_ext[T_W-1] ? TM_W'(-cd_ext) : TM_W'(cd_ext);
   end

   // stages 38 to 49: t = c + x*t for c = C, B, A, four stages per step
   logic signed [COEFF_W-1:0] hcoef [0:HORNER_STEPS-1];
   assign hcoef[0] = coeff_c_ff;
   assign hcoef[1] = coeff_b_ff;
   assign hcoef[2] = coeff_a_ff;

   for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
      logic [X_W+TL_W-1:0]   h1_pl_ff;
      logic [X_W+TH_W-1:0]   h1_ph_ff;
      logic                  h1_neg_ff, h2_neg_ff;
      logic [X_W-1:0]        h1_x_ff, h2_x_ff, h3_x_ff;
      logic                  h1_xn_ff, h2_xn_ff, h3_xn_ff;
      logic [TM_W-1:0]       h2_r_ff;
      logic signed [T_W-1:0] h3_t_ff;
      logic [PR_W-1:0]       prod;
      logic [PR_W-XFRAC-1:0] r_full;
      logic [TM_W-1:0]       r_in;
      logic signed [T_W-1:0] c_ext, sum, t_in;

      always_comb begin
         prod   = {1'b0, h1_ph_ff, {TL_W{1'b0}}} + PR_W'(h1_pl_ff);
         r_full = prod[PR_W-1:XFRAC];
         // product magnitude saturates at the limit
         r_in   = (r_full > (PR_W-XFRAC)'(LIMIT)) ? TM_W'(LIMIT) : r_full[TM_W-1:0];
         c_ext  = {{(T_W-COEFF_W){hcoef[j][COEFF_W-1]}}, hcoef[j]};
         sum    = h2_neg_ff ? c_ext - $signed({1'b0, h2_r_ff})
                            : c_ext + $signed({1'b0, h2_r_ff});
         if (sum > LIM_P) t_in = LIM_P;
         else if (sum < LIM_N) t_in = LIM_N;
         else t_in = sum;
      end

      always_ff @(posedge clock) begin
         h1_pl_ff  <= (X_W+TL_W)'(hb_x_ff[j]) * (X_W+TL_W)'(hb_tm_ff[j][TL_W-1:0]);
         h1_ph_ff  <= (X_W+TH_W)'(hb_x_ff[j]) * (X_W+TH_W)'(hb_tm_ff[j][TM_W-1:TL_W]);
         h1_neg_ff <= hb_xn_ff[j] ^ hb_tn_ff[j];
         h1_x_ff   <= hb_x_ff[j];
         h1_xn_ff  <= hb_xn_ff[j];
         h2_r_ff   <= r_in;
         h2_neg_ff <= h1_neg_ff;
         h2_x_ff   <= h1_x_ff;
         h2_xn_ff  <= h1_xn_ff;
         h3_t_ff   <= t_in;
         h3_x_ff   <= h2_x_ff;
         h3_xn_ff  <= h2_xn_ff;
         hb_tn_ff[j+1] <= h3_t_ff[T_W-1];
         hb_tm_ff[j+1] <= h3_t_ff[T_W-1] ? TM_W'(-h3_t_ff) : TM_W'(h3_t_ff);
         hb_x_ff[j+1]  <= h3_x_ff;
         hb_xn_ff[j+1] <= h3_xn_ff;
      end
   end

   // stage 50: rounded numerator, overflow check against 2^16 quotient
   logic [N_W-1:0]      dv_rem_ff [0:QUO_BITS];
   logic [TM_W-1:0]     dv_us_ff  [0:QUO_BITS];
   logic [QUO_BITS-1:0] dv_q_ff   [0:QUO_BITS];
   logic                dv_big_ff [0:QUO_BITS];
   logic                dv_neg_ff [0:QUO_BITS];
   logic                dv_zero_ff[0:QUO_BITS];
   logic [N_W-1:0]      n_in;
   logic [TM_W-1:0]     us;

   assign us   = hb_tm_ff[HORNER_STEPS];
   assign n_in = K_NUM + N_W'(us >> 1);

   always_ff @(posedge clock) begin
      dv_rem_ff[0]  <= n_in;
      dv_us_ff[0]   <= us;
      dv_q_ff[0]    <= '0;
      dv_big_ff[0]  <= DIV_W'(n_in) >= {1'b0, us, {QUO_BITS{1'b0}}};
      dv_neg_ff[0]  <= hb_tn_ff[HORNER_STEPS];
      dv_zero_ff[0] <= (us == '0);
   end

   // stages 51 to 66: one quotient bit per stage, msb first
   for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
      logic [DIV_W-1:0]    dsh;
      logic                ge;
      logic [QUO_BITS-1:0] q_in;
      always_comb begin
         dsh  = DIV_W'(dv_us_ff[i]) << (QUO_BITS - 1 - i);
         ge   = DIV_W'(dv_rem_ff[i]) >= dsh;
         q_in = dv_q_ff[i];
         q_in[QUO_BITS-1-i] = ge;
      end
      always_ff @(posedge clock) begin
         dv_rem_ff[i+1]  <= ge ? N_W'(DIV_W'(dv_rem_ff[i]) - dsh) : dv_rem_ff[i];
         dv_us_ff[i+1]   <= dv_us_ff[i];
         dv_q_ff[i+1]    <= q_in;
         dv_big_ff[i+1]  <= dv_big_ff[i];
         dv_neg_ff[i+1]  <= dv_neg_ff[i];
         dv_zero_ff[i+1] <= dv_zero_ff[i];
      end
   end

   // stage 67: kelvin to celsius, saturation and status
   logic signed [TK_W-1:0]   q_ext, k_val, t_val;
   logic signed [TEMP_W-1:0] temp_in;
   status_type               status_in;
   logic signed [TEMP_W-1:0] rsp_temp_ff;
   status_type               rsp_status_ff;

   always_comb begin
      q_ext = $signed({3'b000, dv_q_ff[QUO_BITS]});
      k_val = dv_neg_ff[QUO_BITS] ? -q_ext : q_ext;
      t_val = k_val - TK_OFF;
      if (bad_ff[LATENCY-2]) begin
         temp_in   = '0;
         status_in = ST_RANGE;
      end else if (dv_zero_ff[QUO_BITS]) begin
         temp_in   = TEMP_MAX;
         status_in = ST_SAT;
      end else if (dv_big_ff[QUO_BITS]) begin
         temp_in   = dv_neg_ff[QUO_BITS] ? TEMP_MIN : TEMP_MAX;
         status_in = ST_SAT;
      end else if (t_val > TK_MAX) begin
         temp_in   = TEMP_MAX;
         status_in = ST_SAT;
      end else if (t_val < TK_MIN) begin
         temp_in   = TEMP_MIN;
         status_in = ST_SAT;
      end else begin
         temp_in   = t_val[TEMP_W-1:0];
         status_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      rsp_temp_ff   <= temp_in;
      rsp_status_ff <= status_in;
   end

   assign rsp_valid        = vld_ff[LATENCY-1];
   assign rsp_temp_centi_c = rsp_temp_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

### design/tct_checker.sv
// port level checks of the thermistor converter and their bind
`include "thermistor_code_to_temperature_top_macros.svh"

module tct_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic signed [tct_pkg::CODE_W-1:0] req_adc_code,
   input logic                              rsp_valid,
   input logic signed [tct_pkg::TEMP_W-1:0] rsp_temp_centi_c,
   input logic [tct_pkg::STATUS_W-1:0]      rsp_status
);
   import tct_pkg::*;

   // every result beat matches the accepted request beat that it answers
   `TCT_ASSERT_IMP(a_rsp_has_req, clock, reset, rsp_valid, $past(start && !busy, LATENCY))

   // a code that is zero or negative always reports out of range with zero
   `TCT_ASSERT_IMP(a_bad_code, clock, reset, rsp_valid && $past(req_adc_code[CODE_W-1] || (req_adc_code == '0), LATENCY), rsp_status == ST_RANGE && rsp_temp_centi_c == '0)

   // saturated results sit on a rail
   `TCT_ASSERT_IMP(a_sat_rail, clock, reset, rsp_valid && rsp_status == ST_SAT, rsp_temp_centi_c == TEMP_MAX || rsp_temp_centi_c == TEMP_MIN)

   // reset flushes the pipeline
   `TCT_ASSERT_NXT(a_reset_flush, clock, reset, !rsp_valid)

endmodule

bind thermistor_code_to_temperature_top tct_checker u_tct_checker (.*);
